// ===== rtl/core/dse_pkg.sv =====
// shared types, codes and saturating arithmetic for the decision split evaluator
`timescale 1ns / 1ps

package dse_pkg;

    // item commands
    localparam logic [1:0] CMD_FEATURE = 2'd0;
    localparam logic [1:0] CMD_WEIGHT  = 2'd1;
    localparam logic [1:0] CMD_PART    = 2'd2;

    // split modes (the unused code behaves as oblique)
    localparam logic [1:0] MODE_OBLIQUE = 2'd0;
    localparam logic [1:0] MODE_CROSS   = 2'd1;
    localparam logic [1:0] MODE_NOMINAL = 2'd2;

    // register indexes, byte address is 4 * index
    localparam int unsigned ADDR_W = 5;
    localparam logic [2:0] REG_SPLIT_MODE  = 3'd0;
    localparam logic [2:0] REG_STRICT      = 3'd1;
    localparam logic [2:0] REG_BIAS        = 3'd2;
    localparam logic [2:0] REG_FIRST_FEAT  = 3'd3;
    localparam logic [2:0] REG_SECOND_FEAT = 3'd4;
    localparam logic [2:0] REG_FIRST_THR   = 3'd5;
    localparam logic [2:0] REG_SECOND_THR  = 3'd6;

    localparam logic signed [63:0] SUM_MAX = {1'b0, {63{1'b1}}};
    localparam logic signed [63:0] SUM_MIN = {1'b1, {63{1'b0}}};

    typedef struct packed {
        logic [1:0]         split_mode;
        logic               strict_greater;
        logic signed [31:0] bias;
        logic [5:0]         first_feature;
        logic [5:0]         second_feature;
        logic signed [31:0] first_threshold;
        logic signed [31:0] second_threshold;
    } cfg_t;

    // what the front end hands to the accumulator stage
    typedef struct packed {
        logic               valid;
        logic               result;
        logic signed [63:0] prod;
        logic               first_above;
        logic               second_above;
        logic               bad;
        logic [5:0]         part_child;
    } front_t;

    function automatic logic signed [63:0] sat_add64(
        input logic signed [63:0] a,
        input logic signed [63:0] b
    );
        logic signed [64:0] s;
        begin
            s = 65'(a) + 65'(b);
            if (s[64] != s[63])
            begin
                return s[64] ? SUM_MIN : SUM_MAX;
            end
            return s[63:0];
        end
    endfunction

endpackage

// ===== rtl/core/dse_regs.sv =====
// configuration register file behind the apb port
`timescale 1ns / 1ps

module dse_regs
    import dse_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [ADDR_W-1:0]   paddr,
    input  logic [31:0]         pwdata,
    output logic [31:0]         prdata,
    output logic                pready,
    output cfg_t                cfg
);

    // everything zero except second_feature, which starts at 1
    localparam cfg_t CFG_RESET = cfg_t'({2'd0, 1'b0, 32'd0, 6'd0, 6'd1, 32'd0, 32'd0});

    cfg_t       cfg_reg;
    cfg_t       cfg_next;
    logic [2:0] reg_index;
    logic       wr_en;

    assign pready    = 1'b1;
    assign reg_index = paddr[ADDR_W-1:2];
    assign wr_en     = psel && penable && pwrite;
    assign cfg       = cfg_reg;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            unique case (reg_index)
                REG_SPLIT_MODE:  cfg_next.split_mode       = pwdata[1:0];
                REG_STRICT:      cfg_next.strict_greater   = pwdata[0];
                REG_BIAS:        cfg_next.bias             = $signed(pwdata);
                REG_FIRST_FEAT:  cfg_next.first_feature    = pwdata[5:0];
                REG_SECOND_FEAT: cfg_next.second_feature   = pwdata[5:0];
                REG_FIRST_THR:   cfg_next.first_threshold  = $signed(pwdata);
                REG_SECOND_THR:  cfg_next.second_threshold = $signed(pwdata);
                default:         cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= CFG_RESET;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    always_comb
    begin
        unique case (reg_index)
            REG_SPLIT_MODE:  prdata = {30'd0, cfg_reg.split_mode};
            REG_STRICT:      prdata = {31'd0, cfg_reg.strict_greater};
            REG_BIAS:        prdata = cfg_reg.bias;
            REG_FIRST_FEAT:  prdata = {26'd0, cfg_reg.first_feature};
            REG_SECOND_FEAT: prdata = {26'd0, cfg_reg.second_feature};
            REG_FIRST_THR:   prdata = cfg_reg.first_threshold;
            REG_SECOND_THR:  prdata = cfg_reg.second_threshold;
            default:         prdata = 32'd0;
        endcase
    end

endmodule

// ===== rtl/core/dse_front.sv =====
// weight and partition memories, per-sample trackers and the product register
`timescale 1ns / 1ps

module dse_front
    import dse_pkg::*;
#(
    parameter int MAX_FEATURES   = 64,
    parameter int MAX_CATEGORIES = 64
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                adv,
    input  logic                in_valid,
    input  logic [1:0]          cmd,
    input  logic [5:0]          index,
    input  logic signed [31:0]  value,
    input  logic                last,
    input  cfg_t                cfg,
    output front_t              front
);

    localparam int WA = (MAX_FEATURES > 1) ? $clog2(MAX_FEATURES) : 1;
    localparam int CA = (MAX_CATEGORIES > 1) ? $clog2(MAX_CATEGORIES) : 1;

    logic signed [31:0] weight_mem [MAX_FEATURES];
    logic [5:0]         part_mem [MAX_CATEGORIES];

    logic               accept;
    logic               in_feat_range;
    logic               in_cat_range;

    // stage 1
    logic               s1_valid_reg;
    logic [1:0]         s1_cmd_reg;
    logic [5:0]         s1_idx_reg;
    logic signed [31:0] s1_val_reg;
    logic               s1_last_reg;
    logic signed [31:0] wdata_reg;

    // sample trackers
    logic               first_above_reg;
    logic               second_above_reg;
    logic signed [31:0] captured_reg;

    logic               s1_feat;
    logic               s1_in_range;
    logic               first_hit;
    logic               second_hit;
    logic               s1_result;
    logic               first_above_now;
    logic               second_above_now;
    logic signed [31:0] captured_now;
    logic               bad_now;
    logic signed [63:0] prod_now;

    // stage 2
    logic               s2_valid_reg;
    logic               s2_result_reg;
    logic signed [63:0] s2_prod_reg;
    logic               s2_first_reg;
    logic               s2_second_reg;
    logic               s2_bad_reg;
    logic [5:0]         part_rdata_reg;

    assign accept        = in_valid && adv;
    assign in_feat_range = {1'b0, index} < 7'(MAX_FEATURES);
    assign in_cat_range  = {1'b0, index} < 7'(MAX_CATEGORIES);

    always_ff @(posedge clk)
    begin
        if (accept && cmd == CMD_WEIGHT && in_feat_range)
        begin
            weight_mem[index[WA-1:0]] <= value;
        end
        if (accept)
        begin
            wdata_reg <= weight_mem[index[WA-1:0]];
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept && cmd == CMD_PART && in_cat_range)
        begin
            part_mem[index[CA-1:0]] <= value[5:0];
        end
        // a later load lands on the same edge and leaves this read with the old entry
        if (adv)
        begin
            part_rdata_reg <= part_mem[captured_now[CA-1:0]];
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_cmd_reg  <= cmd;
            s1_idx_reg  <= index;
            s1_val_reg  <= value;
            s1_last_reg <= last;
        end
    end

    assign s1_feat     = s1_valid_reg && s1_cmd_reg == CMD_FEATURE;
    assign s1_in_range = {1'b0, s1_idx_reg} < 7'(MAX_FEATURES);
    assign first_hit   = s1_feat && s1_in_range && s1_idx_reg == cfg.first_feature;
    assign second_hit  = s1_feat && s1_in_range && s1_idx_reg == cfg.second_feature;
    assign s1_result   = s1_feat && s1_last_reg;

    assign first_above_now  = first_hit ? (s1_val_reg > cfg.first_threshold) : first_above_reg;
    assign second_above_now = second_hit ? (s1_val_reg > cfg.second_threshold)
                                         : second_above_reg;
    assign captured_now     = first_hit ? s1_val_reg : captured_reg;
    // negative codes look huge as unsigned
    assign bad_now          = $unsigned(captured_now) >= 32'(MAX_CATEGORIES);

    always_comb
    begin
        prod_now = '0;
        if (s1_feat && s1_in_range)
        begin
            prod_now = s1_val_reg * wdata_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg     <= 1'b0;
            s2_valid_reg     <= 1'b0;
            s2_result_reg    <= 1'b0;
            first_above_reg  <= 1'b0;
            second_above_reg <= 1'b0;
            captured_reg     <= '0;
        end
        else if (adv)
        begin
            s1_valid_reg  <= in_valid;
            s2_valid_reg  <= s1_valid_reg;
            s2_result_reg <= s1_result;
            if (s1_result)
            begin
                first_above_reg  <= 1'b0;
                second_above_reg <= 1'b0;
                captured_reg     <= '0;
            end
            else
            begin
                first_above_reg  <= first_above_now;
                second_above_reg <= second_above_now;
                captured_reg     <= captured_now;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s2_prod_reg   <= prod_now;
            s2_first_reg  <= first_above_now;
            s2_second_reg <= second_above_now;
            s2_bad_reg    <= bad_now;
        end
    end

    always_comb
    begin
        front.valid        = s2_valid_reg;
        front.result       = s2_result_reg;
        front.prod         = s2_prod_reg;
        front.first_above  = s2_first_reg;
        front.second_above = s2_second_reg;
        front.bad          = s2_bad_reg;
        front.part_child   = part_rdata_reg;
    end

endmodule

// ===== rtl/core/dse_back.sv =====
// saturating accumulator, split decision and output register
`timescale 1ns / 1ps

module dse_back
    import dse_pkg::*;
#(
    parameter int FRAC_BITS = 16
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  front_t      front,
    input  cfg_t        cfg,
    output logic        adv,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [5:0]  child,
    output logic        bad_category
);

    logic signed [63:0] sum_reg;
    logic signed [63:0] sum_acc;

    logic               s3_result_reg;
    logic signed [63:0] s3_sum_reg;
    logic               s3_first_reg;
    logic               s3_second_reg;
    logic               s3_bad_reg;
    logic [5:0]         s3_part_reg;

    logic signed [63:0] bias_sh;
    logic signed [63:0] margin;
    logic               zero_side;
    logic [5:0]         child_now;
    logic               bad_now;

    logic               out_valid_reg;
    logic [5:0]         child_reg;
    logic               bad_reg;

    // only a result that has nowhere to go holds the pipeline
    assign adv = !(out_valid_reg && out_stall && s3_result_reg);

    assign sum_acc = sat_add64(sum_reg, front.prod);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sum_reg       <= '0;
            s3_result_reg <= 1'b0;
        end
        else if (adv)
        begin
            s3_result_reg <= front.valid && front.result;
            if (front.valid)
            begin
                sum_reg <= front.result ? '0 : sum_acc;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv && front.valid && front.result)
        begin
            s3_sum_reg    <= sum_acc;
            s3_first_reg  <= front.first_above;
            s3_second_reg <= front.second_above;
            s3_bad_reg    <= front.bad;
            s3_part_reg   <= front.part_child;
        end
    end

    // bias is far below the 64-bit limits, so negating it cannot overflow
    assign bias_sh   = 64'(cfg.bias) <<< FRAC_BITS;
    assign margin    = sat_add64(s3_sum_reg, -bias_sh);
    assign zero_side = !margin[63] && (!cfg.strict_greater || margin != '0);

    always_comb
    begin
        bad_now = 1'b0;
        unique case (cfg.split_mode)
            MODE_CROSS:
            begin
                child_now = {4'd0, s3_second_reg, s3_first_reg};
            end
            MODE_NOMINAL:
            begin
                bad_now   = s3_bad_reg;
                child_now = s3_bad_reg ? 6'd0 : s3_part_reg;
            end
            default:
            begin
                child_now = zero_side ? 6'd0 : 6'd1;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (adv && s3_result_reg)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv && s3_result_reg)
        begin
            child_reg <= child_now;
            bad_reg   <= bad_now;
        end
    end

    assign out_valid    = out_valid_reg;
    assign child        = child_reg;
    assign bad_category = bad_reg;

    a_bad_forces_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && bad_reg |-> child_reg == 6'd0)
        else $error("bad category with nonzero child");

    a_sum_cleared: assert property (@(posedge clk) disable iff (!rst_n)
        adv && front.valid && front.result |=> sum_reg == '0)
        else $error("accumulator not cleared after a sample");

    a_cross_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && cfg.split_mode == MODE_CROSS |-> child_reg[5:2] == 4'd0)
        else $error("cross child out of range");

    a_result_held: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && out_stall && s3_result_reg |=> out_valid_reg && s3_result_reg)
        else $error("pending result dropped under stall");

endmodule

// ===== rtl/core/decision_split_evaluator.sv =====
// decision split evaluator: configuration, front end and decision stages
// Evaluates one split rule (oblique hyperplane, two-feature cross or nominal
// partition) on samples whose features stream in as items, one per cycle.
// Input channel in_valid/in_stall carries cmd, index, value, last: feature
// elements, weight loads and partition loads. A feature item with last set
// closes the sample and yields one item on out_valid/out_stall (child,
// bad_category); every other item yields nothing.
// Throughput: one item per cycle while in_stall is low, loads and features
// alike. The accumulator loop is a single 64-bit saturating add, and the
// weight memory port takes one read and one write per cycle.
// A sample's result passes stage 1, stage 2, the decision stage and the
// output register (memory read, multiply, accumulate, decide) to out_valid.
// Receiver stall: the output register holds its item; items with no result
// keep flowing, and in_stall rises, in the same cycle as out_stall, only while
// a further result waits in the decision stage behind the held item.
// Reset clears the configuration (second_feature to 1), the sample trackers
// and the pipeline. Weight and partition memories are not cleared and must be
// loaded before use. Users write configuration via the apb port while idle (unenforced).
`timescale 1ns / 1ps

module decision_split_evaluator
    import dse_pkg::*;
#(
    parameter int MAX_FEATURES   = 64,
    parameter int MAX_CATEGORIES = 64,
    parameter int FRAC_BITS      = 16
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [ADDR_W-1:0]   paddr,
    input  logic [31:0]         pwdata,
    output logic [31:0]         prdata,
    output logic                pready,
    input  logic                in_valid,
    output logic                in_stall,
    input  logic [1:0]          cmd,
    input  logic [5:0]          index,
    input  logic signed [31:0]  value,
    input  logic                last,
    output logic                out_valid,
    input  logic                out_stall,
    output logic [5:0]          child,
    output logic                bad_category
);

    cfg_t   cfg;
    front_t front;
    logic   adv;

    assign in_stall = !adv;

    dse_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    dse_front #(
        .MAX_FEATURES   (MAX_FEATURES),
        .MAX_CATEGORIES (MAX_CATEGORIES)
    ) u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .adv      (adv),
        .in_valid (in_valid),
        .cmd      (cmd),
        .index    (index),
        .value    (value),
        .last     (last),
        .cfg      (cfg),
        .front    (front)
    );

    dse_back #(
        .FRAC_BITS (FRAC_BITS)
    ) u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .front        (front),
        .cfg          (cfg),
        .adv          (adv),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .child        (child),
        .bad_category (bad_category)
    );

endmodule

// ===== verif/tb.sv =====
// self-checking testbench for decision_split_evaluator against a local split predictor
`timescale 1ns / 1ps

module tb;
    import dse_pkg::*;

    localparam int FRAC_BITS     = 16;
    localparam int RANDOM_ITEMS  = 600;
    localparam int PHASE_ITEMS   = 100;
    localparam int SETTLE_CYCLES = 8;
    localparam int STALL_LIMIT   = 2000;

    localparam logic [1:0]  CMD_UNUSED  = 2'd3;
    localparam logic [1:0]  MODE_UNUSED = 2'd3;
    localparam logic [2:0]  REG_NONE    = 3'd7;
    localparam logic [31:0] WORD_MIN    = 32'h8000_0000;
    localparam logic [31:0] WORD_MAX    = 32'h7fff_ffff;

    typedef struct packed {
        logic [1:0]  cmd;
        logic [5:0]  index;
        logic [31:0] value;
        logic        last;
    } item_t;

    typedef struct packed {
        logic [5:0] child;
        logic       bad;
    } verdict_t;

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               psel = 1'b0;
    logic               penable = 1'b0;
    logic               pwrite = 1'b0;
    logic [ADDR_W-1:0]  paddr = '0;
    logic [31:0]        pwdata = '0;
    logic [31:0]        prdata;
    logic               pready;
    logic               in_valid = 1'b0;
    logic               in_stall;
    logic [1:0]         cmd = CMD_FEATURE;
    logic [5:0]         index = '0;
    logic signed [31:0] value = '0;
    logic               last = 1'b0;
    logic               out_valid;
    logic               out_stall = 1'b0;
    logic [5:0]         child;
    logic               bad_category;

    decision_split_evaluator dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .cmd          (cmd),
        .index        (index),
        .value        (value),
        .last         (last),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .child        (child),
        .bad_category (bad_category)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // items waiting to be driven, splits waiting to come out
    item_t    feed_items[$];
    verdict_t awaited_splits[$];

    bit in_fire;
    bit out_fire;
    bit gaps_on = 1'b1;
    int error_count;
    int quiet_cycles;

    // predictor copy of the block
    cfg_t               rules;
    logic signed [31:0] weight_mem [64];
    logic [5:0]         part_mem [64];
    logic signed [63:0] acc;
    logic               first_hit;
    logic               second_hit;
    logic signed [31:0] cat_code;

    // what the stimulus generator believes is programmed
    logic [1:0]  gen_mode;
    logic [5:0]  gen_first;
    logic [5:0]  gen_second;
    logic [31:0] gen_thr1;
    logic [31:0] gen_thr2;

    task automatic flag_error(input string msg);
        error_count++;
        if (error_count <= 10)
        begin
            $display("mismatch at %0t: %s", $realtime, msg);
        end
    endtask

    function automatic logic signed [63:0] clamp_add(
        input logic signed [63:0] a,
        input logic signed [63:0] b
    );
        logic signed [63:0] s;
        s = a + b;
        // overflow only when both operands share a sign the sum lost
        if (a[63] == b[63] && s[63] != a[63])
        begin
            return a[63] ? SUM_MIN : SUM_MAX;
        end
        return s;
    endfunction

    function automatic void store_reg(input logic [2:0] idx, input logic [31:0] data);
        case (idx)
            REG_SPLIT_MODE:  rules.split_mode = data[1:0];
            REG_STRICT:      rules.strict_greater = data[0];
            REG_BIAS:        rules.bias = data;
            REG_FIRST_FEAT:  rules.first_feature = data[5:0];
            REG_SECOND_FEAT: rules.second_feature = data[5:0];
            REG_FIRST_THR:   rules.first_threshold = data;
            REG_SECOND_THR:  rules.second_threshold = data;
            default: ;
        endcase
    endfunction

    function automatic bit evaluate_item(input item_t it, output verdict_t v);
        logic signed [63:0] wide_w;
        logic signed [63:0] wide_v;
        logic signed [63:0] bias_wide;
        logic signed [63:0] margin;
        v = '0;
        case (it.cmd)
            CMD_WEIGHT:
            begin
                weight_mem[it.index] = it.value;
                return 1'b0;
            end
            CMD_PART:
            begin
                part_mem[it.index] = it.value[5:0];
                return 1'b0;
            end
            CMD_FEATURE: ;
            default: return 1'b0;
        endcase

        // every feature feeds all three rules whatever the mode
        wide_w = weight_mem[it.index];
        wide_v = $signed(it.value);
        acc = clamp_add(acc, wide_w * wide_v);
        if (it.index == rules.first_feature)
        begin
            first_hit = $signed(it.value) > $signed(rules.first_threshold);
            cat_code = it.value;
        end
        if (it.index == rules.second_feature)
        begin
            second_hit = $signed(it.value) > $signed(rules.second_threshold);
        end
        if (!it.last)
        begin
            return 1'b0;
        end

        case (rules.split_mode)
            MODE_CROSS:
            begin
                v.child = {4'd0, second_hit, first_hit};
            end
            MODE_NOMINAL:
            begin
                if (cat_code < 0 || cat_code > 63)
                begin
                    v.bad = 1'b1;
                end
                else
                begin
                    v.child = part_mem[cat_code[5:0]];
                end
            end
            default:
            begin
                bias_wide = $signed(rules.bias);
                margin = clamp_add(acc, -(bias_wide <<< FRAC_BITS));
                v.child = (rules.strict_greater ? (margin > 0) : (margin >= 0)) ? 6'd0 : 6'd1;
            end
        endcase
        acc = '0;
        first_hit = 1'b0;
        second_hit = 1'b0;
        cat_code = '0;
        return 1'b1;
    endfunction

    // driver: inputs change on the falling edge
    always @(negedge clk)
    begin : drive
        item_t nxt;
        if (rst_n)
        begin
            if (!in_valid || in_fire)
            begin
                if (feed_items.size() != 0 && !(gaps_on && $urandom_range(0, 99) < 21))
                begin
                    nxt = feed_items.pop_front();
                    cmd <= nxt.cmd;
                    index <= nxt.index;
                    value <= nxt.value;
                    last <= nxt.last;
                    in_valid <= 1'b1;
                end
                else
                begin
                    in_valid <= 1'b0;
                end
            end
            out_stall <= gaps_on && ($urandom_range(0, 99) < 21);
        end
    end

    // monitor: handshakes and register writes sampled on the rising edge
    always @(posedge clk)
    begin : watch
        verdict_t want;
        item_t taken;
        in_fire = rst_n && in_valid && !in_stall;
        out_fire = rst_n && out_valid && !out_stall;
        if (out_fire)
        begin
            if (awaited_splits.size() == 0)
            begin
                flag_error($sformatf("result with nothing pending: child=%0d bad=%0b",
                                     child, bad_category));
            end
            else
            begin
                want = awaited_splits.pop_front();
                if (child !== want.child)
                begin
                    flag_error($sformatf("child expected %0d got %0d", want.child, child));
                end
                if (bad_category !== want.bad)
                begin
                    flag_error($sformatf("bad_category expected %0b got %0b",
                                         want.bad, bad_category));
                end
            end
        end
        if (in_fire)
        begin
            taken.cmd = cmd;
            taken.index = index;
            taken.value = value;
            taken.last = last;
            if (evaluate_item(taken, want))
            begin
                awaited_splits.push_back(want);
            end
        end
        if (rst_n && psel && penable && pwrite && pready)
        begin
            store_reg(paddr[ADDR_W-1:2], pwdata);
        end
        quiet_cycles = (!rst_n || in_fire || out_fire || psel) ? 0 : quiet_cycles + 1;
    end

    initial
    begin
        while (quiet_cycles < STALL_LIMIT)
        begin
            @(posedge clk);
        end
        $display("FAILURE");
        $finish;
    end

    task automatic queue_item(
        input logic [1:0]  op,
        input logic [5:0]  idx,
        input logic [31:0] data,
        input logic        fin
    );
        item_t it;
        it.cmd = op;
        it.index = idx;
        it.value = data;
        it.last = fin;
        feed_items.push_back(it);
    endtask

    // wait for the pipe to empty, including items that give no result
    task automatic settle();
        while (feed_items.size() != 0 || in_valid || awaited_splits.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic [2:0] idx, input logic [31:0] data);
        @(negedge clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= ADDR_W'({idx, 2'b00});
        pwdata <= data;
        @(negedge clk);
        penable <= 1'b1;
        @(negedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
    endtask

    task automatic set_rules(
        input logic [1:0]  mode,
        input logic        strict,
        input logic [31:0] bias,
        input logic [5:0]  f1,
        input logic [5:0]  f2,
        input logic [31:0] t1,
        input logic [31:0] t2
    );
        logic [31:0] junk;
        // narrow registers get garbage in their unused upper bits
        junk = $urandom;
        write_reg(REG_SPLIT_MODE, {junk[31:2], mode});
        write_reg(REG_STRICT, {junk[31:1], strict});
        write_reg(REG_BIAS, bias);
        write_reg(REG_FIRST_FEAT, {junk[31:6], f1});
        write_reg(REG_SECOND_FEAT, {junk[31:6], f2});
        write_reg(REG_FIRST_THR, t1);
        write_reg(REG_SECOND_THR, t2);
        write_reg(REG_NONE, $urandom);
        gen_mode = mode;
        gen_first = f1;
        gen_second = f2;
        gen_thr1 = t1;
        gen_thr2 = t2;
    endtask

    function automatic logic [31:0] shaped_word();
        logic [31:0] raw;
        raw = $urandom;
        case ($urandom_range(0, 7))
            0: return 32'd0;
            1: return raw[0] ? WORD_MIN : WORD_MAX;
            2, 3, 4: return {{12{raw[19]}}, raw[19:0]};
            default: return raw;
        endcase
    endfunction

    function automatic logic [5:0] pick_index();
        case ($urandom_range(0, 3))
            0: return gen_first;
            1: return gen_second;
            default: return 6'($urandom);
        endcase
    endfunction

    function automatic logic [31:0] feature_word(input logic [5:0] idx);
        int unsigned roll;
        roll = $urandom_range(0, 99);
        if (gen_mode == MODE_NOMINAL && idx == gen_first && roll < 70)
        begin
            return 32'($urandom_range(0, 63));
        end
        // land right around the thresholds so both compare outcomes show up
        if (idx == gen_first && roll < 40)
        begin
            return gen_thr1 + 32'($urandom_range(0, 4)) - 32'd2;
        end
        if (idx == gen_second && roll < 40)
        begin
            return gen_thr2 + 32'($urandom_range(0, 4)) - 32'd2;
        end
        return shaped_word();
    endfunction

    initial
    begin : stimulus
        logic [31:0] wt;
        logic [1:0]  mode;
        logic [1:0]  op;
        logic [5:0]  idx;
        int          load_count;
        int          phase_items;
        int          phase;
        int          len;
        rules = '0;
        rules.second_feature = 6'd1;
        acc = '0;
        first_hit = 1'b0;
        second_hit = 1'b0;
        cat_code = '0;
        gen_mode = MODE_OBLIQUE;
        gen_first = 6'd0;
        gen_second = 6'd1;
        gen_thr1 = '0;
        gen_thr2 = '0;
        load_count = 0;
        phase = 0;

        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // fill both tables so no entry is ever read unwritten
        for (int k = 0; k < 64; k++)
        begin
            wt = $urandom;
            if (k == 0)
                wt = WORD_MIN;
            else if (k == 1)
                wt = WORD_MAX;
            else if ($urandom_range(0, 1) == 1)
                wt = {{12{wt[19]}}, wt[19:0]};
            queue_item(CMD_WEIGHT, 6'(k), wt, 1'b0);
        end
        queue_item(CMD_PART, 6'd0, 32'h0000_0040, 1'b0);
        for (int k = 1; k < 64; k++)
        begin
            queue_item(CMD_PART, 6'(k), $urandom, 1'b0);
        end

        // oblique at reset values: saturate high, saturate low, exact zero
        queue_item(CMD_FEATURE, 6'd0, WORD_MIN, 1'b0);
        queue_item(CMD_FEATURE, 6'd0, WORD_MIN, 1'b0);
        queue_item(CMD_FEATURE, 6'd0, WORD_MIN, 1'b1);
        queue_item(CMD_FEATURE, 6'd1, WORD_MIN, 1'b0);
        queue_item(CMD_FEATURE, 6'd1, WORD_MIN, 1'b0);
        queue_item(CMD_FEATURE, 6'd1, WORD_MIN, 1'b1);
        queue_item(CMD_FEATURE, 6'd5, 32'd0, 1'b1);
        // last on ignored and load items must not close a sample
        queue_item(CMD_UNUSED, 6'd63, WORD_MAX, 1'b1);
        queue_item(CMD_WEIGHT, 6'd0, WORD_MIN, 1'b1);
        queue_item(CMD_PART, 6'd63, 32'hffff_ffff, 1'b1);
        queue_item(CMD_FEATURE, 6'd63, WORD_MAX, 1'b1);
        settle();

        set_rules(MODE_OBLIQUE, 1'b1, 32'd0, 6'd0, 6'd1, 32'd0, 32'd0);
        queue_item(CMD_FEATURE, 6'd5, 32'd0, 1'b1);
        queue_item(CMD_FEATURE, 6'd0, WORD_MIN, 1'b0);
        queue_item(CMD_FEATURE, 6'd0, WORD_MIN, 1'b1);
        settle();

        set_rules(MODE_OBLIQUE, 1'b0, WORD_MIN, 6'd0, 6'd1, 32'd0, 32'd0);
        queue_item(CMD_FEATURE, 6'd0, WORD_MIN, 1'b0);
        queue_item(CMD_FEATURE, 6'd0, WORD_MIN, 1'b0);
        queue_item(CMD_FEATURE, 6'd0, WORD_MIN, 1'b1);
        queue_item(CMD_FEATURE, 6'd5, 32'd0, 1'b1);
        settle();

        // unused mode code falls back to oblique
        set_rules(MODE_UNUSED, 1'b0, WORD_MAX, 6'd0, 6'd1, 32'd0, 32'd0);
        queue_item(CMD_FEATURE, 6'd5, 32'd0, 1'b1);
        queue_item(CMD_FEATURE, 6'd1, WORD_MIN, 1'b0);
        queue_item(CMD_FEATURE, 6'd1, WORD_MIN, 1'b1);
        settle();

        // cross with extreme thresholds, then a sample missing both features
        set_rules(MODE_CROSS, 1'b0, 32'd0, 6'd0, 6'd63, WORD_MAX, WORD_MIN);
        queue_item(CMD_FEATURE, 6'd0, WORD_MAX, 1'b0);
        queue_item(CMD_FEATURE, 6'd63, 32'h8000_0001, 1'b1);
        queue_item(CMD_FEATURE, 6'd10, WORD_MAX, 1'b1);
        settle();

        set_rules(MODE_CROSS, 1'b0, 32'd0, 6'd0, 6'd63, WORD_MIN, WORD_MAX);
        queue_item(CMD_FEATURE, 6'd63, WORD_MAX, 1'b0);
        queue_item(CMD_FEATURE, 6'd0, WORD_MIN, 1'b0);
        queue_item(CMD_FEATURE, 6'd0, 32'h8000_0001, 1'b1);
        settle();

        // nominal: top valid code, codes outside the table, feature absent
        set_rules(MODE_NOMINAL, 1'b0, 32'd0, 6'd63, 6'd0, 32'd0, 32'd0);
        queue_item(CMD_FEATURE, 6'd63, 32'd63, 1'b1);
        queue_item(CMD_FEATURE, 6'd63, 32'd64, 1'b1);
        queue_item(CMD_FEATURE, 6'd63, 32'hffff_ffff, 1'b1);
        queue_item(CMD_FEATURE, 6'd63, WORD_MIN, 1'b1);
        queue_item(CMD_FEATURE, 6'd63, WORD_MAX, 1'b1);
        queue_item(CMD_FEATURE, 6'd5, 32'd7, 1'b1);

        while (load_count < RANDOM_ITEMS)
        begin
            settle();
            mode = 2'($urandom_range(0, 3));
            set_rules(mode, 1'($urandom), shaped_word(), 6'($urandom), 6'($urandom),
                      shaped_word(), shaped_word());
            // one phase runs flat out on both sides
            gaps_on = (phase != 3);
            phase_items = 0;
            while (phase_items < PHASE_ITEMS)
            begin
                if ($urandom_range(0, 9) == 0)
                begin
                    op = 2'($urandom_range(1, 3));
                    queue_item(op, 6'($urandom), $urandom, 1'($urandom));
                    if (op != CMD_UNUSED)
                        phase_items++;
                end
                else
                begin
                    len = $urandom_range(1, 6);
                    for (int k = 0; k < len; k++)
                    begin
                        idx = pick_index();
                        queue_item(CMD_FEATURE, idx, feature_word(idx), k == len - 1);
                    end
                    phase_items += len;
                end
            end
            load_count += phase_items;
            phase++;
        end
        settle();

        if (awaited_splits.size() != 0)
        begin
            flag_error($sformatf("%0d results never arrived", awaited_splits.size()));
        end
        if (error_count == 0)
        begin
            $display("SUCCESS");
        end
        else
        begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule
